[hw/rtl/olist_pkg.sv]
`timescale 1ns / 1ps

package olist_pkg;

	// list geometry
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// fixed field widths
	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	// command codes
	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND     = 3'd0,
		OP_PREPEND    = 3'd1,
		OP_SEARCH     = 3'd2,
		OP_REMOVE_VAL = 3'd3,
		OP_REMOVE_IDX = 3'd4
	} opcode_t;

	// status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	// command request
	typedef struct packed {
		logic [OPCODE_W-1:0]       opcode;
		logic signed [VALUE_W-1:0] value;
		logic [INDEX_W-1:0]        index;
	} req_t;

	// command result
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [POS_W-1:0]    position;
		logic [COUNT_W-1:0]  count;
		logic                empty_res;
	} res_t;

	// per-cell update control, load wins over shifts
	typedef struct packed {
		logic load;
		logic shr;
		logic shl;
	} cell_ctrl_t;

endpackage

[hw/rtl/olist_cell.sv]
`timescale 1ns / 1ps

module olist_cell (
	input  logic                            clk,
	input  olist_pkg::cell_ctrl_t           ctrl,
	input  logic [olist_pkg::VALUE_W-1:0]   load_val,
	input  logic [olist_pkg::VALUE_W-1:0]   left_data,
	input  logic [olist_pkg::VALUE_W-1:0]   right_data,
	input  logic [olist_pkg::VALUE_W-1:0]   cmp_val,
	output logic [olist_pkg::VALUE_W-1:0]   data,
	output logic                            match
);

	logic [olist_pkg::VALUE_W-1:0] data_q;

	// entry storage: load, take from the head side or take from the tail side
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_val;
		end else if (ctrl.shr) begin
			data_q <= left_data;
		end else if (ctrl.shl) begin
			data_q <= right_data;
		end
	end

	// local compare against the broadcast value
	assign match = (data_q == cmp_val);
	assign data  = data_q;

endmodule

[hw/rtl/ordered_list_engine_core.sv]
`timescale 1ns / 1ps

// Bounded ordered list of up to 16 signed 32-bit values, held in a row of
// cells where position 0 is the head. A request is taken when start is high
// and busy is low; its result appears on res for exactly one cycle with done
// high, and must be captured then since it cannot be held off. Append,
// prepend, search and remove-at-index finish in the cycle they are taken,
// with done in the next cycle and busy never raised. Remove-by-value walks
// the list one position per cycle with a single compare-and-shift step over
// the cell row, but a match holds the position while the gap closes. Busy
// is high for the walk and drops in the cycle done rises. Control state is
// reset; entries hold no reset value and are never read before written.
module ordered_list_engine_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  olist_pkg::req_t   req,
	output logic              done,
	output olist_pkg::res_t   res
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	localparam int CAP = olist_pkg::CAPACITY;
	localparam int VW  = olist_pkg::VALUE_W;
	localparam int IW  = olist_pkg::IDX_W;
	localparam int CW  = olist_pkg::CNT_W;

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         p_q, p_d;
	logic                  removed_q, removed_d;
	logic [VW-1:0]         val_q, val_d;
	logic                  done_q, done_d;
	olist_pkg::res_t       res_q, res_d;

	olist_pkg::cell_ctrl_t ctrl [CAP];
	logic [VW-1:0]         cell_data [CAP];
	logic [CAP-1:0]        match_vec;
	logic [CAP-1:0]        hit_vec;
	logic [VW-1:0]         cmp_val;
	logic                  accept;
	logic                  any_hit;
	logic [IW-1:0]         first_pos;
	logic [CW-1:0]         req_idx;

	assign accept  = start && (state_q == S_IDLE);
	assign cmp_val = (state_q == S_SCAN) ? val_q : VW'(req.value);
	assign req_idx = CW'(req.index);

	// row of cells, each neighbor feeds the next in both directions
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		logic [VW-1:0] left_d, right_d;
		if (g == 0) begin : g_head
			assign left_d = VW'(req.value);
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end
		if (g == CAP - 1) begin : g_tail
			assign right_d = cell_data[g];
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end
		olist_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[g]),
			.load_val   (VW'(req.value)),
			.left_data  (left_d),
			.right_data (right_d),
			.cmp_val    (cmp_val),
			.data       (cell_data[g]),
			.match      (match_vec[g])
		);
		// only occupied positions count as hits
		assign hit_vec[g] = match_vec[g] && (CW'(g) < count_q);
	end

	// first hit from the head
	always_comb begin
		first_pos = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				first_pos = IW'(i);
			end
		end
	end
	assign any_hit = |hit_vec;

	// command decode and scan step
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		p_d       = p_q;
		removed_d = removed_q;
		val_d     = val_q;
		done_d    = 1'b0;
		res_d     = res_q;
		for (int i = 0; i < CAP; i++) begin
			ctrl[i] = '0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d.status   = olist_pkg::ST_OK;
					res_d.found    = 1'b0;
					res_d.position = '0;
					done_d         = 1'b1;
					case (req.opcode)
						olist_pkg::OP_APPEND: begin
							if (count_q == CW'(CAP)) begin
								res_d.status = olist_pkg::ST_FULL;
							end else begin
								for (int i = 0; i < CAP; i++) begin
									ctrl[i].load = (CW'(i) == count_q);
								end
								count_d = count_q + 1'b1;
							end
						end
						olist_pkg::OP_PREPEND: begin
							if (count_q == CW'(CAP)) begin
								res_d.status = olist_pkg::ST_FULL;
							end else begin
								ctrl[0].load = 1'b1;
								for (int i = 1; i < CAP; i++) begin
									ctrl[i].shr = 1'b1;
								end
								count_d = count_q + 1'b1;
							end
						end
						olist_pkg::OP_SEARCH: begin
							if (count_q == '0) begin
								res_d.status = olist_pkg::ST_EMPTY;
							end else if (any_hit) begin
								res_d.found    = 1'b1;
								res_d.position = olist_pkg::POS_W'(first_pos);
							end else begin
								res_d.status = olist_pkg::ST_NOT_FOUND;
							end
						end
						olist_pkg::OP_REMOVE_VAL: begin
							if (count_q == '0) begin
								res_d.status = olist_pkg::ST_EMPTY;
							end else begin
								done_d    = 1'b0;
								state_d   = S_SCAN;
								p_d       = '0;
								removed_d = 1'b0;
								val_d     = VW'(req.value);
							end
						end
						olist_pkg::OP_REMOVE_IDX: begin
							if (req_idx >= count_q) begin
								res_d.status = olist_pkg::ST_RANGE;
							end else begin
								for (int i = 0; i < CAP; i++) begin
									ctrl[i].shl = (CW'(i) >= req_idx);
								end
								count_d     = count_q - 1'b1;
								res_d.found = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (p_q >= count_q) begin
					// walk finished
					state_d        = S_IDLE;
					done_d         = 1'b1;
					res_d.found    = removed_q;
					res_d.position = '0;
					res_d.status   = removed_q ? olist_pkg::ST_OK : olist_pkg::ST_NOT_FOUND;
				end else if (match_vec[p_q[IW-1:0]]) begin
					// close the gap at the scan position
					for (int i = 0; i < CAP; i++) begin
						ctrl[i].shl = (CW'(i) >= p_q);
					end
					count_d   = count_q - 1'b1;
					removed_d = 1'b1;
				end else begin
					p_d = p_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		res_d.count     = olist_pkg::COUNT_W'(count_d);
		res_d.empty_res = (count_d == '0);
	end

	// state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			p_q       <= '0;
			removed_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			p_q       <= p_d;
			removed_q <= removed_d;
			done_q    <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		val_q <= val_d;
		res_q <= res_d;
	end

	assign busy = (state_q == S_SCAN);
	assign done = done_q;
	assign res  = res_q;

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAP))
		else $error("entry count above capacity");

	// a result never shows while a walk is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe during removal walk");

	// every taken request either reports at once or starts a walk
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("request dropped");

	// scan position stays within the shrinking list
	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (p_q <= count_q))
		else $error("scan position past list end");

	// a walk only ever shrinks the list
	a_scan_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (count_q <= $past(count_q)))
		else $error("count grew during removal walk");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import olist_pkg::*;

	// opcodes the block ignores
	localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

	localparam int RUN_ITEMS = 1400;
	localparam int QUIET_TAIL = 200;
	localparam int DRAIN_AT = 700;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		req_t cmd;
		int   reps;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	res_t res;

	ordered_list_engine_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.res   (res)
	);

	always #4 clk = ~clk;

	// shadow copy of the list
	logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
	int shadow_count = 0;

	res_t pending_results [$];
	dir_row_t directed_cmds [$];
	int fail_count = 0;
	int results_checked = 0;
	int reqs_by_op [8];
	int hit_total = 0;
	int full_rejects = 0;
	int peak_count = 0;

	// apply one command to the shadow list and return its result
	function automatic res_t apply_list_command(req_t cmd);
		res_t r;
		int keep;
		r = '0;
		r.status = ST_OK;
		case (cmd.opcode)
			OP_APPEND: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_entries[shadow_count] = cmd.value;
					shadow_count++;
				end
			end
			OP_PREPEND: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (int i = shadow_count; i > 0; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[0] = cmd.value;
					shadow_count++;
				end
			end
			OP_SEARCH: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status = ST_NOT_FOUND;
					for (int i = 0; i < shadow_count; i++) begin
						if (!r.found && shadow_entries[i] == cmd.value) begin
							r.status = ST_OK;
							r.found = 1'b1;
							r.position = POS_W'(i);
						end
					end
				end
			end
			OP_REMOVE_VAL: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					keep = 0;
					for (int i = 0; i < shadow_count; i++) begin
						if (shadow_entries[i] != cmd.value) begin
							shadow_entries[keep] = shadow_entries[i];
							keep++;
						end
					end
					if (keep == shadow_count) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.found = 1'b1;
						shadow_count = keep;
					end
				end
			end
			OP_REMOVE_IDX: begin
				if (int'(cmd.index) >= shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = cmd.index; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
					r.found = 1'b1;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_count);
		r.empty_res = (shadow_count == 0);
		return r;
	endfunction

	function automatic res_t outcome(logic [STATUS_W-1:0] st, logic f, int p, int c, logic e);
		res_t r;
		r.status = st;
		r.found = f;
		r.position = POS_W'(p);
		r.count = COUNT_W'(c);
		r.empty_res = e;
		return r;
	endfunction

	function automatic dir_row_t cmd_row(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] v,
			int idx, int reps, bit typed, res_t want);
		dir_row_t row;
		row.cmd.opcode = op;
		row.cmd.value = v;
		row.cmd.index = INDEX_W'(idx);
		row.reps = reps;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	// values drawn mostly from a small pool so searches and removals hit
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0001;
			5: return 32'h0000_0007;
			default: return $urandom;
		endcase
	endfunction

	// random request, weighted toward growing or shrinking the list
	function automatic req_t random_cmd(bit filling);
		req_t cmd;
		int roll;
		roll = $urandom_range(0, 99);
		cmd.value = pick_value();
		if (shadow_count > 0 && $urandom_range(0, 2) != 0)
			cmd.index = INDEX_W'($urandom_range(0, shadow_count - 1));
		else
			cmd.index = INDEX_W'($urandom_range(0, 15));
		if (filling) begin
			if (roll < 40) cmd.opcode = OP_APPEND;
			else if (roll < 65) cmd.opcode = OP_PREPEND;
			else if (roll < 80) cmd.opcode = OP_SEARCH;
			else if (roll < 88) cmd.opcode = OP_REMOVE_VAL;
			else if (roll < 98) cmd.opcode = OP_REMOVE_IDX;
			else cmd.opcode = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end else begin
			if (roll < 15) cmd.opcode = OP_APPEND;
			else if (roll < 25) cmd.opcode = OP_PREPEND;
			else if (roll < 45) cmd.opcode = OP_SEARCH;
			else if (roll < 70) cmd.opcode = OP_REMOVE_VAL;
			else if (roll < 97) cmd.opcode = OP_REMOVE_IDX;
			else cmd.opcode = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end
		return cmd;
	endfunction

	// drive one request and hold it until taken
	task automatic issue_request(input req_t cmd, input bit typed, input res_t want);
		res_t predicted;
		req <= cmd;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = apply_list_command(cmd);
		if (typed)
			predicted = want;
		pending_results.push_back(predicted);
		reqs_by_op[cmd.opcode]++;
		if (predicted.found) hit_total++;
		if (predicted.status == ST_FULL) full_rejects++;
		if (shadow_count > peak_count) peak_count = shadow_count;
	endtask

	// random sender gap
	task automatic sender_gap(input bit allow);
		if (allow && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: %p", res);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					fail_count++;
				end
				if (res.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, res.found);
					fail_count++;
				end
				if (res.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, res.position);
					fail_count++;
				end
				if (res.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, res.count);
					fail_count++;
				end
				if (res.empty_res !== want.empty_res) begin
					$error("empty_res: expected %0d, got %0d", want.empty_res, res.empty_res);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		bit filling;
		bit allow_gap;
		int ignored_reqs;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		directed_cmds.push_back(cmd_row(OP_SEARCH, 0, 0, 1, 1, outcome(ST_EMPTY, 0, 0, 0, 1)));
		directed_cmds.push_back(cmd_row(OP_REMOVE_VAL, 0, 0, 1, 1,
			outcome(ST_EMPTY, 0, 0, 0, 1)));
		directed_cmds.push_back(cmd_row(OP_REMOVE_IDX, 0, 0, 1, 1,
			outcome(ST_RANGE, 0, 0, 0, 1)));
		directed_cmds.push_back(cmd_row(OP_REMOVE_IDX, 0, 15, 1, 1,
			outcome(ST_RANGE, 0, 0, 0, 1)));
		directed_cmds.push_back(cmd_row(OP_UNUSED_LO, 32'h5a5a_5a5a, 9, 1, 1,
			outcome(ST_OK, 0, 0, 0, 1)));
		// extremes at both ends
		directed_cmds.push_back(cmd_row(OP_APPEND, 32'h8000_0000, 0, 1, 1,
			outcome(ST_OK, 0, 0, 1, 0)));
		directed_cmds.push_back(cmd_row(OP_APPEND, 32'h7fff_ffff, 0, 1, 1,
			outcome(ST_OK, 0, 0, 2, 0)));
		directed_cmds.push_back(cmd_row(OP_PREPEND, 32'h0000_0000, 0, 1, 1,
			outcome(ST_OK, 0, 0, 3, 0)));
		directed_cmds.push_back(cmd_row(OP_PREPEND, 32'hffff_ffff, 15, 1, 1,
			outcome(ST_OK, 0, 0, 4, 0)));
		directed_cmds.push_back(cmd_row(OP_SEARCH, 32'h7fff_ffff, 0, 1, 1,
			outcome(ST_OK, 1, 3, 4, 0)));
		directed_cmds.push_back(cmd_row(OP_SEARCH, 32'h8000_0000, 0, 1, 0, '0));
		directed_cmds.push_back(cmd_row(OP_SEARCH, 12345, 0, 1, 1,
			outcome(ST_NOT_FOUND, 0, 0, 4, 0)));
		directed_cmds.push_back(cmd_row(OP_REMOVE_IDX, 0, 15, 1, 1,
			outcome(ST_RANGE, 0, 0, 4, 0)));
		directed_cmds.push_back(cmd_row(OP_REMOVE_VAL, 12345, 0, 1, 1,
			outcome(ST_NOT_FOUND, 0, 0, 4, 0)));
		// fill up, then insert into a full list
		directed_cmds.push_back(cmd_row(OP_APPEND, 7, 0, 12, 0, '0));
		directed_cmds.push_back(cmd_row(OP_APPEND, 1, 0, 1, 1,
			outcome(ST_FULL, 0, 0, 16, 0)));
		directed_cmds.push_back(cmd_row(OP_PREPEND, 1, 0, 1, 1,
			outcome(ST_FULL, 0, 0, 16, 0)));
		directed_cmds.push_back(cmd_row(OP_SEARCH, 7, 0, 1, 1, outcome(ST_OK, 1, 4, 16, 0)));
		directed_cmds.push_back(cmd_row(OP_REMOVE_VAL, 7, 0, 1, 1,
			outcome(ST_OK, 1, 0, 4, 0)));
		// tail and head removal, then remove by value down to empty
		directed_cmds.push_back(cmd_row(OP_REMOVE_IDX, 0, 3, 1, 0, '0));
		directed_cmds.push_back(cmd_row(OP_REMOVE_IDX, 0, 0, 1, 0, '0));
		directed_cmds.push_back(cmd_row(OP_PREPEND, 0, 0, 1, 0, '0));
		directed_cmds.push_back(cmd_row(OP_REMOVE_IDX, 0, 2, 1, 0, '0));
		directed_cmds.push_back(cmd_row(OP_REMOVE_VAL, 0, 0, 1, 1,
			outcome(ST_OK, 1, 0, 0, 1)));
		directed_cmds.push_back(cmd_row(OP_UNUSED_HI, 32'hffff_ffff, 15, 1, 1,
			outcome(ST_OK, 0, 0, 0, 1)));

		foreach (directed_cmds[k]) begin
			repeat (directed_cmds[k].reps) begin
				issue_request(directed_cmds[k].cmd, directed_cmds[k].typed,
					directed_cmds[k].want);
				sender_gap(1'b1);
			end
		end

		// random part: alternating fill and drain phases
		for (int n = 0; n < RUN_ITEMS; n++) begin
			filling = ((n / 60) % 2) == 0;
			// no gap right before the drain point, which drops start itself
			allow_gap = (n < RUN_ITEMS - QUIET_TAIL) && ((n / 150) % 3 != 2) &&
				(n != DRAIN_AT - 1);
			if (n == DRAIN_AT) begin
				start <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end else begin
				issue_request(random_cmd(filling), 1'b0, '0);
				sender_gap(allow_gap);
			end
		end
		start <= 1'b0;

		// drain and settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		ignored_reqs = 0;
		for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
			ignored_reqs += reqs_by_op[op];
		$display("tb: requests: %0d append, %0d prepend, %0d search, %0d by value, %0d by index",
			reqs_by_op[OP_APPEND], reqs_by_op[OP_PREPEND], reqs_by_op[OP_SEARCH],
			reqs_by_op[OP_REMOVE_VAL], reqs_by_op[OP_REMOVE_IDX]);
		$display("tb: %0d ignored, %0d checked, %0d hits, %0d full rejects, peak occupancy %0d",
			ignored_reqs, results_checked, hit_total, full_rejects, peak_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
